/* design/hsvcw_pkg.sv */
package hsvcw_pkg;

  localparam int HUE_W  = 16;
  localparam int CHAN_W = 8;
  localparam int MODE_W = 2;
  localparam int SEG_W  = 3;
  localparam int HRED_W = SEG_W + CHAN_W;   // reduced hue, below 1536

  localparam logic [CHAN_W-1:0] CMAX = '1;

  // Wheel mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_FULL = 2'd0,
    MODE_RG   = 2'd1,
    MODE_GB   = 2'd2,
    MODE_BR   = 2'd3
  } wheel_mode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // x mod 3, one bit per step (msb first)
  function automatic logic [1:0] mod3_7(input logic [6:0] x);
    logic [1:0] r;
    logic [2:0] t;
    r = 2'd0;
    for (int i = 6; i >= 0; i--) begin
      t = {r, x[i]};
      r = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    end
    return r;
  endfunction

endpackage

/* design/hsvcw_in_if.sv */
interface hsvcw_in_if
  import hsvcw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [CHAN_W-1:0] saturation;
  logic [CHAN_W-1:0] level;
  logic [MODE_W-1:0] wheel_mode;

  modport source (output valid, output hue, output saturation, output level,
                  output wheel_mode, input ready);
  modport sink   (input valid, input hue, input saturation, input level,
                  input wheel_mode, output ready);
endinterface

/* design/hsvcw_out_if.sv */
interface hsvcw_out_if
  import hsvcw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* design/hsv_color_wheel_to_rgb.sv */
// Integer color-wheel HSV to RGB converter. Each transaction on in_ch carries a
// 16-bit hue, 8-bit saturation, 8-bit level and a 2-bit wheel mode, and yields
// exactly one red/green/blue transaction on out_ch, in order. Mode 0 reduces hue
// mod 1536 and walks the six-sextant wheel; modes 1..3 reduce hue mod 1024 and
// sweep back and forth along the red-green, green-blue or blue-red edge.
// Saturation pulls each channel toward 255, then level scales it by (v+1)/256.
// Throughput is one transaction per clock while out_ch is not stalled. There are
// four register stages: hue reduction, wheel lookup, saturation multiply and
// level multiply. The first stage loads at the accepting edge, and the output
// turns valid after the later stages. Each stage holds its item only while the
// stage after it is full and stalled, so bubbles are squeezed out and
// in_ch.ready stays high whenever out_ch is being drained or is empty.
module hsv_color_wheel_to_rgb
  import hsvcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hsvcw_in_if.sink    in_ch,
  hsvcw_out_if.source out_ch
);

  // ---------------------------------------------------------------------
  // Stage valids and the ready chain. A stage may load when it is empty
  // or when its content moves on in the same cycle.
  // ---------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: hue reduction. 1536 = 3 * 512, so hue mod 1536 is
  // ((hue >> 9) mod 3) in the top two bits above hue[8:0]. Line modes
  // just keep the low ten bits.
  // ---------------------------------------------------------------------
  wheel_mode_t       mode_in;
  logic [HRED_W-1:0] h_nxt;
  logic [HRED_W-1:0] h1_r;
  logic [CHAN_W-1:0] s1_r, lv1_r;
  wheel_mode_t       mode1_r;

  assign mode_in = wheel_mode_t'(in_ch.wheel_mode);

  always_comb begin
    if (mode_in == MODE_FULL) begin
      h_nxt = {mod3_7(in_ch.hue[15:9]), in_ch.hue[8:0]};
    end else begin
      h_nxt = {1'b0, in_ch.hue[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      h1_r    <= h_nxt;
      s1_r    <= in_ch.saturation;
      lv1_r   <= in_ch.level;
      mode1_r <= mode_in;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: wheel lookup. Top bits of the reduced hue pick the segment,
  // the low byte is the ramp within it.
  // ---------------------------------------------------------------------
  logic [SEG_W-1:0]  seg;
  logic [CHAN_W-1:0] lo;
  rgb_t              base_nxt;
  rgb_t              base2_r;
  logic [CHAN_W-1:0] s2_r, lv2_r;

  assign seg = h1_r[HRED_W-1:CHAN_W];
  assign lo  = h1_r[CHAN_W-1:0];

  always_comb begin
    base_nxt = '0;
    unique case (mode1_r)
      MODE_FULL: begin
        unique case (seg)
          3'd0:    base_nxt = '{red: CMAX,      green: lo,        blue: '0};
          3'd1:    base_nxt = '{red: CMAX - lo, green: CMAX,      blue: '0};
          3'd2:    base_nxt = '{red: '0,        green: CMAX,      blue: lo};
          3'd3:    base_nxt = '{red: '0,        green: CMAX - lo, blue: CMAX};
          3'd4:    base_nxt = '{red: lo,        green: '0,        blue: CMAX};
          default: base_nxt = '{red: CMAX,      green: '0,        blue: CMAX - lo};
        endcase
      end
      MODE_RG: begin
        unique case (seg)
          3'd0:    base_nxt = '{red: CMAX,      green: lo,        blue: '0};
          3'd1:    base_nxt = '{red: CMAX - lo, green: CMAX,      blue: '0};
          3'd2:    base_nxt = '{red: lo,        green: CMAX,      blue: '0};
          default: base_nxt = '{red: CMAX,      green: CMAX - lo, blue: '0};
        endcase
      end
      MODE_GB: begin
        unique case (seg)
          3'd0:    base_nxt = '{red: '0, green: CMAX,      blue: lo};
          3'd1:    base_nxt = '{red: '0, green: CMAX - lo, blue: CMAX};
          3'd2:    base_nxt = '{red: '0, green: lo,        blue: CMAX};
          default: base_nxt = '{red: '0, green: CMAX,      blue: CMAX - lo};
        endcase
      end
      MODE_BR: begin
        unique case (seg)
          3'd0:    base_nxt = '{red: lo,        green: '0, blue: CMAX};
          3'd1:    base_nxt = '{red: CMAX,      green: '0, blue: CMAX - lo};
          3'd2:    base_nxt = '{red: CMAX,      green: '0, blue: lo};
          default: base_nxt = '{red: CMAX - lo, green: '0, blue: CMAX};
        endcase
      end
      default: base_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      base2_r <= base_nxt;
      s2_r    <= s1_r;
      lv2_r   <= lv1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: saturation. c' = 255 - (((255 - c) * (s + 1)) >> 8).
  // 255 - x on 8 bits is ~x; the product is at most 255 * 256.
  // ---------------------------------------------------------------------
  logic [CHAN_W:0]     s_inc;
  logic [2*CHAN_W-1:0] pr, pg, pb;
  rgb_t                sat3_r;
  logic [CHAN_W-1:0]   lv3_r;

  assign s_inc = {1'b0, s2_r} + (CHAN_W+1)'(1);
  assign pr = {{CHAN_W{1'b0}}, ~base2_r.red}   * {{(CHAN_W-1){1'b0}}, s_inc};
  assign pg = {{CHAN_W{1'b0}}, ~base2_r.green} * {{(CHAN_W-1){1'b0}}, s_inc};
  assign pb = {{CHAN_W{1'b0}}, ~base2_r.blue}  * {{(CHAN_W-1){1'b0}}, s_inc};

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      sat3_r.red   <= ~pr[2*CHAN_W-1:CHAN_W];
      sat3_r.green <= ~pg[2*CHAN_W-1:CHAN_W];
      sat3_r.blue  <= ~pb[2*CHAN_W-1:CHAN_W];
      lv3_r        <= lv2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: level. out = (c' * (v + 1)) >> 8, never above 255.
  // This stage is also the output register.
  // ---------------------------------------------------------------------
  logic [CHAN_W:0]     v_inc;
  logic [2*CHAN_W-1:0] qr, qg, qb;
  rgb_t                out4_r;

  assign v_inc = {1'b0, lv3_r} + (CHAN_W+1)'(1);
  assign qr = {{CHAN_W{1'b0}}, sat3_r.red}   * {{(CHAN_W-1){1'b0}}, v_inc};
  assign qg = {{CHAN_W{1'b0}}, sat3_r.green} * {{(CHAN_W-1){1'b0}}, v_inc};
  assign qb = {{CHAN_W{1'b0}}, sat3_r.blue}  * {{(CHAN_W-1){1'b0}}, v_inc};

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      out4_r.red   <= qr[2*CHAN_W-1:CHAN_W];
      out4_r.green <= qg[2*CHAN_W-1:CHAN_W];
      out4_r.blue  <= qb[2*CHAN_W-1:CHAN_W];
    end
  end

  assign out_ch.valid = v4_r;
  assign out_ch.red   = out4_r.red;
  assign out_ch.green = out4_r.green;
  assign out_ch.blue  = out4_r.blue;

endmodule

/* design/hsvcw_checker.sv */
module hsvcw_checker
  import hsvcw_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_blue
);

  // No result may appear straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("out valid right after reset");

  // A drained or empty output must never throttle the input
  a_no_throttle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled while output drains");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("out valid dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("out payload changed under stall");

endmodule

bind hsv_color_wheel_to_rgb hsvcw_checker u_hsvcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red),
  .out_green (out_ch.green),
  .out_blue  (out_ch.blue)
);
